[rtl/kmst_pkg.sv]
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared types and constants of the maximum spanning tree block.
// ----------------------------------------------------------------------------
`default_nettype none

package kmst_pkg;

  // register indexes of the configuration port
  localparam logic [1:0] REG_COST_SCALE   = 2'd0;
  localparam logic [1:0] REG_GAIN_SCALE   = 2'd1;
  localparam logic [1:0] REG_VERTEX_COUNT = 2'd2;

  // field widths
  localparam int VERT_W   = 8;
  localparam int VAL_W    = 16;
  localparam int SUM_W    = 24;
  localparam int SCORE_W  = 42;
  localparam int TAKEN_W  = 8;
  localparam int VCNT_W   = 9;
  localparam int KEY_W    = 34;
  localparam int PROD_W   = 33;
  localparam int RANK_W   = 4;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 104;

  // datapath operations issued by the controller
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_IDLE     = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 5'd2;
  localparam logic [OP_W-1:0] OP_SCAN_RD  = 5'd3;
  localparam logic [OP_W-1:0] OP_SCAN_MUL = 5'd4;
  localparam logic [OP_W-1:0] OP_SCAN_CMP = 5'd5;
  localparam logic [OP_W-1:0] OP_EDGE_RD  = 5'd6;
  localparam logic [OP_W-1:0] OP_EDGE_CHK = 5'd7;
  localparam logic [OP_W-1:0] OP_FIND_RD  = 5'd8;
  localparam logic [OP_W-1:0] OP_FA_CHK   = 5'd9;
  localparam logic [OP_W-1:0] OP_FB_CHK   = 5'd10;
  localparam logic [OP_W-1:0] OP_RANK_A   = 5'd11;
  localparam logic [OP_W-1:0] OP_RANK_B   = 5'd12;
  localparam logic [OP_W-1:0] OP_UNION    = 5'd13;
  localparam logic [OP_W-1:0] OP_NEXT     = 5'd14;
  localparam logic [OP_W-1:0] OP_SCORE1   = 5'd15;
  localparam logic [OP_W-1:0] OP_SCORE2   = 5'd16;
  localparam logic [OP_W-1:0] OP_OUT      = 5'd17;

  // datapath status seen by the controller
  typedef struct packed {
    logic last_acc;   // last edge word accepted
    logic out_done;   // result word taken
    logic clr_end;    // clearing pass at final vertex
    logic no_target;  // single vertex, nothing to join
    logic scan_end;   // scan at final stored edge
    logic best_valid; // scan found a next edge
    logic bad_edge;   // endpoint out of range
    logic root_hit;   // parent read equals current vertex
    logic same_root;  // both endpoints in one component
    logic tree_full;  // this union completes the tree
  } status_t;

endpackage

`default_nettype wire

[rtl/kruskal_max_spanning_tree.sv]
// ----------------------------------------------------------------------------
// kruskal_max_spanning_tree
// Maximum spanning tree of a loaded edge list, by key-ordered selection and a
// union-find with union by rank.
// ----------------------------------------------------------------------------
// Edges load one per cycle until the word with tlast; edges past MAX_EDGES
// are dropped and flagged. The block then clears the union-find over the
// clamped vertex count, and picks edges in descending key order by scanning
// all n stored edges for the next one, each read, multiplied and compared in
// turn through the single edge memory read port, then closing the scan. Each
// picked edge is then fetched and range checked, each of its two root walks
// reads and checks the parent of every vertex visited, and the two root ranks
// are read before the join and the scan restart; a stray edge or one inside a
// single component skips the rest. Once the tree completes or no edge is
// left, the score is formed from products and their difference, then one
// result word is sent. No edge is accepted until the result word is taken.
`default_nettype none

module kruskal_max_spanning_tree #(
  parameter int MAX_VERTICES = 256,
  parameter int MAX_EDGES    = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // edge_from, edge_to, edge_profit, edge_cost
  input  wire logic [47:0]   s_axis_tdata,
  // last_edge
  input  wire logic          s_axis_tlast,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // profit_total, cost_total, tree_score, edges_taken, overflow_flag, zero pad
  output logic [103:0]       m_axis_tdata
);

  logic [kmst_pkg::OP_W-1:0] op;
  kmst_pkg::status_t         status;

  kmst_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  kmst_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

[rtl/kmst_ctrl.sv]
// ----------------------------------------------------------------------------
// kmst_ctrl
// Sequencer: load, clear union-find, select edges by repeated scan, find
// roots, join, then compute the score and present the result.
// ----------------------------------------------------------------------------
`default_nettype none

module kmst_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire kmst_pkg::status_t         status,
  output logic [kmst_pkg::OP_W-1:0]      op
);

  localparam logic [4:0] S_LOAD     = 5'd0;
  localparam logic [4:0] S_CLEAR    = 5'd1;
  localparam logic [4:0] S_SCAN_RD  = 5'd2;
  localparam logic [4:0] S_SCAN_MUL = 5'd3;
  localparam logic [4:0] S_SCAN_CMP = 5'd4;
  localparam logic [4:0] S_SCAN_END = 5'd5;
  localparam logic [4:0] S_EDGE_RD  = 5'd6;
  localparam logic [4:0] S_EDGE_CHK = 5'd7;
  localparam logic [4:0] S_FA_RD    = 5'd8;
  localparam logic [4:0] S_FA_CHK   = 5'd9;
  localparam logic [4:0] S_FB_RD    = 5'd10;
  localparam logic [4:0] S_FB_CHK   = 5'd11;
  localparam logic [4:0] S_RANK_A   = 5'd12;
  localparam logic [4:0] S_RANK_B   = 5'd13;
  localparam logic [4:0] S_UNION    = 5'd14;
  localparam logic [4:0] S_NEXT     = 5'd15;
  localparam logic [4:0] S_SCORE1   = 5'd16;
  localparam logic [4:0] S_SCORE2   = 5'd17;
  localparam logic [4:0] S_OUT      = 5'd18;

  logic [4:0] state, state_next;

  // next state
  always_comb begin
    state_next = state;
    op         = kmst_pkg::OP_IDLE;
    case (state)
      S_LOAD: begin
        op = kmst_pkg::OP_LOAD;
        if (status.last_acc) state_next = S_CLEAR;
      end
      S_CLEAR: begin
        op = kmst_pkg::OP_CLEAR;
        if (status.clr_end) state_next = status.no_target ? S_SCORE1 : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        op = kmst_pkg::OP_SCAN_RD;
        state_next = S_SCAN_MUL;
      end
      S_SCAN_MUL: begin
        op = kmst_pkg::OP_SCAN_MUL;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        op = kmst_pkg::OP_SCAN_CMP;
        state_next = status.scan_end ? S_SCAN_END : S_SCAN_RD;
      end
      S_SCAN_END: begin
        state_next = status.best_valid ? S_EDGE_RD : S_SCORE1;
      end
      S_EDGE_RD: begin
        op = kmst_pkg::OP_EDGE_RD;
        state_next = S_EDGE_CHK;
      end
      S_EDGE_CHK: begin
        op = kmst_pkg::OP_EDGE_CHK;
        state_next = status.bad_edge ? S_NEXT : S_FA_RD;
      end
      S_FA_RD: begin
        op = kmst_pkg::OP_FIND_RD;
        state_next = S_FA_CHK;
      end
      S_FA_CHK: begin
        op = kmst_pkg::OP_FA_CHK;
        state_next = status.root_hit ? S_FB_RD : S_FA_RD;
      end
      S_FB_RD: begin
        op = kmst_pkg::OP_FIND_RD;
        state_next = S_FB_CHK;
      end
      S_FB_CHK: begin
        op = kmst_pkg::OP_FB_CHK;
        if (status.root_hit) state_next = status.same_root ? S_NEXT : S_RANK_A;
        else state_next = S_FB_RD;
      end
      S_RANK_A: begin
        op = kmst_pkg::OP_RANK_A;
        state_next = S_RANK_B;
      end
      S_RANK_B: begin
        op = kmst_pkg::OP_RANK_B;
        state_next = S_UNION;
      end
      S_UNION: begin
        op = kmst_pkg::OP_UNION;
        state_next = status.tree_full ? S_SCORE1 : S_NEXT;
      end
      S_NEXT: begin
        op = kmst_pkg::OP_NEXT;
        state_next = S_SCAN_RD;
      end
      S_SCORE1: begin
        op = kmst_pkg::OP_SCORE1;
        state_next = S_SCORE2;
      end
      S_SCORE2: begin
        op = kmst_pkg::OP_SCORE2;
        state_next = S_OUT;
      end
      S_OUT: begin
        op = kmst_pkg::OP_OUT;
        if (status.out_done) state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else state <= state_next;
  end

endmodule

`default_nettype wire

[rtl/kmst_datapath.sv]
// ----------------------------------------------------------------------------
// kmst_datapath
// Edge store, key multipliers, scan selection registers, union-find
// memories, totals and score.
// ----------------------------------------------------------------------------
`default_nettype none

module kmst_datapath #(
  parameter int MAX_VERTICES = 256,
  parameter int MAX_EDGES    = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [kmst_pkg::OP_W-1:0]     op,
  output kmst_pkg::status_t                  status,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [15:0]                   cfg_data,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [kmst_pkg::IN_W-1:0]     s_axis_tdata,
  input  wire logic                          s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [kmst_pkg::OUT_W-1:0]         m_axis_tdata
);

  localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int FW  = $clog2(MAX_EDGES + 1);
  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int TW  = (VCW > kmst_pkg::TAKEN_W) ? VCW : kmst_pkg::TAKEN_W;
  localparam int EW  = 2 * kmst_pkg::VERT_W + 2 * kmst_pkg::VAL_W;

  // configuration registers
  logic signed [15:0]              cost_scale, gain_scale;
  logic [kmst_pkg::VCNT_W-1:0]     vertex_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cost_scale   <= 16'sd0;
      gain_scale   <= 16'sd1;
      vertex_count <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        kmst_pkg::REG_COST_SCALE:   cost_scale   <= cfg_data;
        kmst_pkg::REG_GAIN_SCALE:   gain_scale   <= cfg_data;
        kmst_pkg::REG_VERTEX_COUNT: vertex_count <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // load handshake
  logic in_acc, out_acc;
  assign s_axis_tready = (op == kmst_pkg::OP_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (op == kmst_pkg::OP_OUT);
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  // snapshot of scales and clamped vertex count
  logic signed [15:0] gain, cost;
  logic [VCW-1:0]     vc;
  logic [VCW-1:0]     vc_clamp;

  always_comb begin
    if (vertex_count == '0) vc_clamp = VCW'(1);
    else if (32'(vertex_count) > MAX_VERTICES) vc_clamp = VCW'(MAX_VERTICES);
    else vc_clamp = VCW'(vertex_count);
  end

  // fill count and drop flag
  logic [FW-1:0] fill;
  logic          dropped;
  logic          has_room;
  assign has_room = (32'(fill) < MAX_EDGES);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      dropped <= 1'b0;
    end else if (out_acc) begin
      fill    <= '0;
      dropped <= 1'b0;
    end else if (in_acc) begin
      if (has_room) fill <= fill + FW'(1);
      else dropped <= 1'b1;
    end
  end

  // edge store: one write port, one registered read
  logic [EW-1:0] edge_mem [MAX_EDGES];
  logic [EW-1:0] edge_rd;
  logic [AW-1:0] scan_idx, best_idx, last_idx;

  always_ff @(posedge clk) begin
    if (in_acc && has_room) edge_mem[fill[AW-1:0]] <= s_axis_tdata;
    if (op == kmst_pkg::OP_SCAN_RD) edge_rd <= edge_mem[scan_idx];
    else if (op == kmst_pkg::OP_EDGE_RD) edge_rd <= edge_mem[best_idx];
  end

  logic [7:0]  e_from, e_to;
  logic [15:0] e_profit, e_cost;
  assign e_from   = edge_rd[7:0];
  assign e_to     = edge_rd[15:8];
  assign e_profit = edge_rd[31:16];
  assign e_cost   = edge_rd[47:32];

  // key products, one register stage
  logic signed [kmst_pkg::PROD_W-1:0] prod_g, prod_c;
  logic signed [kmst_pkg::KEY_W-1:0]  key;
  always_ff @(posedge clk) begin
    if (op == kmst_pkg::OP_SCAN_MUL) begin
      prod_g <= gain * $signed({1'b0, e_profit});
      prod_c <= cost * $signed({1'b0, e_cost});
    end
  end
  assign key = kmst_pkg::KEY_W'(prod_g) - kmst_pkg::KEY_W'(prod_c);

  // scan selection: best edge strictly after the previous pick
  logic                              best_valid, have_last;
  logic signed [kmst_pkg::KEY_W-1:0] best_key, last_key;
  logic                              after, better;

  assign after  = !have_last || (key < last_key) ||
                  ((key == last_key) && (scan_idx > last_idx));
  assign better = !best_valid || (key > best_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
      have_last  <= 1'b0;
      scan_idx   <= '0;
    end else begin
      case (op)
        kmst_pkg::OP_LOAD: begin
          best_valid <= 1'b0;
          have_last  <= 1'b0;
          scan_idx   <= '0;
        end
        kmst_pkg::OP_SCAN_CMP: begin
          if (after && better) begin
            best_valid <= 1'b1;
            best_key   <= key;
            best_idx   <= scan_idx;
          end
          scan_idx <= scan_idx + AW'(1);
        end
        kmst_pkg::OP_EDGE_RD: begin
          have_last <= 1'b1;
          last_key  <= best_key;
          last_idx  <= best_idx;
        end
        kmst_pkg::OP_NEXT: begin
          best_valid <= 1'b0;
          scan_idx   <= '0;
        end
        default: ;
      endcase
    end
  end

  // union-find memories
  logic [VW-1:0]              parent_mem [MAX_VERTICES];
  logic [kmst_pkg::RANK_W-1:0] rank_mem  [MAX_VERTICES];
  logic [VW-1:0]              parent_rd, cur_v, root_a;
  logic [kmst_pkg::RANK_W-1:0] rank_rd, rank_a;
  logic [VCW-1:0]             clr_v;

  always_ff @(posedge clk) begin
    case (op)
      kmst_pkg::OP_CLEAR: begin
        parent_mem[clr_v[VW-1:0]] <= clr_v[VW-1:0];
        rank_mem[clr_v[VW-1:0]]   <= '0;
      end
      kmst_pkg::OP_UNION: begin
        if (rank_a > rank_rd) begin
          parent_mem[cur_v] <= root_a;
        end else if (rank_a < rank_rd) begin
          parent_mem[root_a] <= cur_v;
        end else begin
          parent_mem[cur_v] <= root_a;
          rank_mem[root_a]  <= rank_a + kmst_pkg::RANK_W'(1);
        end
      end
      default: ;
    endcase
    if (op == kmst_pkg::OP_FIND_RD) parent_rd <= parent_mem[cur_v];
    if (op == kmst_pkg::OP_RANK_A) rank_rd <= rank_mem[root_a];
    else if (op == kmst_pkg::OP_RANK_B) rank_rd <= rank_mem[cur_v];
  end

  // root walk registers; cur_v ends as root of the second endpoint
  always_ff @(posedge clk) begin
    case (op)
      kmst_pkg::OP_EDGE_CHK: cur_v <= VW'(e_from);
      kmst_pkg::OP_FA_CHK: begin
        if (parent_rd == cur_v) begin
          root_a <= cur_v;
          cur_v  <= VW'(e_to);
        end else begin
          cur_v <= parent_rd;
        end
      end
      kmst_pkg::OP_FB_CHK: begin
        if (parent_rd != cur_v) cur_v <= parent_rd;
      end
      kmst_pkg::OP_RANK_B: rank_a <= rank_rd;
      default: ;
    endcase
  end

  // snapshot, clear counter, totals
  logic [kmst_pkg::SUM_W-1:0] psum, csum;
  logic [TW-1:0]              taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_v <= '0;
    end else begin
      case (op)
        kmst_pkg::OP_LOAD: begin
          if (in_acc && s_axis_tlast) begin
            gain  <= gain_scale;
            cost  <= cost_scale;
            vc    <= vc_clamp;
            clr_v <= '0;
            psum  <= '0;
            csum  <= '0;
            taken <= '0;
          end
        end
        kmst_pkg::OP_CLEAR: clr_v <= clr_v + VCW'(1);
        kmst_pkg::OP_UNION: begin
          psum  <= psum + kmst_pkg::SUM_W'(e_profit);
          csum  <= csum + kmst_pkg::SUM_W'(e_cost);
          taken <= taken + TW'(1);
        end
        default: ;
      endcase
    end
  end

  // score: products then difference
  logic signed [40:0]                  sc_g, sc_c;
  logic signed [kmst_pkg::SCORE_W-1:0] score;
  always_ff @(posedge clk) begin
    if (op == kmst_pkg::OP_SCORE1) begin
      sc_g <= gain * $signed({1'b0, psum});
      sc_c <= cost * $signed({1'b0, csum});
    end
    if (op == kmst_pkg::OP_SCORE2) begin
      score <= kmst_pkg::SCORE_W'(sc_g) - kmst_pkg::SCORE_W'(sc_c);
    end
  end

  assign m_axis_tdata = {5'd0, dropped, taken[kmst_pkg::TAKEN_W-1:0] , score, csum, psum};

  // status
  always_comb begin
    status.last_acc   = in_acc && s_axis_tlast;
    status.out_done   = out_acc;
    status.clr_end    = (clr_v == vc - VCW'(1));
    status.no_target  = (vc == VCW'(1));
    status.scan_end   = (FW'(scan_idx) + FW'(1) == fill);
    status.best_valid = best_valid;
    status.bad_edge   = (32'(e_from) >= 32'(vc)) || (32'(e_to) >= 32'(vc));
    status.root_hit   = (parent_rd == cur_v);
    status.same_root  = (cur_v == root_a);
    status.tree_full  = (32'(taken) + 1 == 32'(vc) - 1);
  end

endmodule

`default_nettype wire

[rtl/kmst_checker.sv]
// ----------------------------------------------------------------------------
// kmst_checker
// Port-level checks of the spanning tree block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kmst_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [103:0] m_axis_tdata
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped or changed while stalled");

  // loading and result never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");

  // after reset the block loads
  a_reset_load: assert property (@(posedge clk)
    rst |=> s_axis_tready)
    else $error("not loading after reset");

  // one result per graph, then back to loading
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready && !m_axis_tvalid)
    else $error("no return to loading after result");

endmodule

bind kruskal_max_spanning_tree kmst_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[tb/sv/kmst_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmst_scoreboard
// Watches the edge, result and register ports of the spanning tree block,
// predicts each tree result from the accepted edge words and compares it.
// ----------------------------------------------------------------------------
`default_nettype none

module kmst_scoreboard #(
  parameter int MAX_VERTICES = 256,
  parameter int MAX_EDGES    = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  input  wire logic          s_axis_tvalid,
  input  wire logic          s_axis_tready,
  input  wire logic [47:0]   s_axis_tdata,
  input  wire logic          s_axis_tlast,
  input  wire logic          m_axis_tvalid,
  input  wire logic          m_axis_tready,
  input  wire logic [103:0]  m_axis_tdata,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [kmst_pkg::SUM_W-1:0]   profit_total;
    logic [kmst_pkg::SUM_W-1:0]   cost_total;
    logic [kmst_pkg::SCORE_W-1:0] tree_score;
    logic [kmst_pkg::TAKEN_W-1:0] edges_taken;
    logic                         overflow_flag;
  } tree_result_t;

  // mirror of the block state
  logic [kmst_pkg::IN_W-1:0]         graph_edges [MAX_EDGES];
  int                                graph_fill;
  bit                                graph_dropped;
  logic signed [kmst_pkg::VAL_W-1:0] cost_mult;
  logic signed [kmst_pkg::VAL_W-1:0] gain_mult;
  logic [kmst_pkg::VCNT_W-1:0]       vcount;

  tree_result_t expected_trees [$];

  // Kruskal over the stored edges, keys ordered high to low, ties by arrival
  function automatic tree_result_t predict_tree();
    longint       keys [MAX_EDGES];
    int           order [MAX_EDGES];
    int           parent [MAX_VERTICES];
    int           vc, goal, taken, cur, j, rf, rt, f, t;
    longint       psum, csum, score;
    tree_result_t r;
    vc = int'(vcount);
    if (vc < 1) vc = 1;
    if (vc > MAX_VERTICES) vc = MAX_VERTICES;
    goal = vc - 1;
    for (int i = 0; i < graph_fill; i++) begin
      keys[i] = longint'(gain_mult) * longint'(graph_edges[i][31:16])
              - longint'(cost_mult) * longint'(graph_edges[i][47:32]);
      order[i] = i;
    end
    // stable insertion sort, descending
    for (int i = 1; i < graph_fill; i++) begin
      cur = order[i];
      j = i - 1;
      while (j >= 0 && keys[order[j]] < keys[cur]) begin
        order[j + 1] = order[j];
        j--;
      end
      order[j + 1] = cur;
    end
    for (int v = 0; v < MAX_VERTICES; v++) parent[v] = v;
    taken = 0;
    psum = 0;
    csum = 0;
    for (int i = 0; i < graph_fill && taken < goal; i++) begin
      f = int'(graph_edges[order[i]][7:0]);
      t = int'(graph_edges[order[i]][15:8]);
      if (f >= vc || t >= vc) continue;
      rf = f;
      while (parent[rf] != rf) rf = parent[rf];
      rt = t;
      while (parent[rt] != rt) rt = parent[rt];
      if (rf != rt) begin
        parent[rf] = rt;
        psum += longint'(graph_edges[order[i]][31:16]);
        csum += longint'(graph_edges[order[i]][47:32]);
        taken++;
      end
    end
    psum &= 64'hFF_FFFF;
    csum &= 64'hFF_FFFF;
    score = longint'(gain_mult) * psum - longint'(cost_mult) * csum;
    r.profit_total  = psum[kmst_pkg::SUM_W-1:0];
    r.cost_total    = csum[kmst_pkg::SUM_W-1:0];
    r.tree_score    = score[kmst_pkg::SCORE_W-1:0];
    r.edges_taken   = taken[kmst_pkg::TAKEN_W-1:0];
    r.overflow_flag = graph_dropped;
    return r;
  endfunction

  // register writes, edge words, result words
  always @(posedge clk) begin
    tree_result_t want, got;
    if (rst) begin
      graph_fill    = 0;
      graph_dropped = 0;
      cost_mult     = '0;
      gain_mult     = 16'sd1;
      vcount        = 9'd256;
      errors        = 0;
      expected_trees.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          kmst_pkg::REG_COST_SCALE:   cost_mult = cfg_data;
          kmst_pkg::REG_GAIN_SCALE:   gain_mult = cfg_data;
          kmst_pkg::REG_VERTEX_COUNT: vcount    = cfg_data[kmst_pkg::VCNT_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (graph_fill < MAX_EDGES) begin
          graph_edges[graph_fill] = s_axis_tdata;
          graph_fill++;
        end else begin
          graph_dropped = 1;
        end
        if (s_axis_tlast) begin
          expected_trees.push_back(predict_tree());
          graph_fill    = 0;
          graph_dropped = 0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.profit_total  = m_axis_tdata[23:0];
        got.cost_total    = m_axis_tdata[47:24];
        got.tree_score    = m_axis_tdata[89:48];
        got.edges_taken   = m_axis_tdata[97:90];
        got.overflow_flag = m_axis_tdata[98];
        if (expected_trees.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result word with none pending: %h",
                     $realtime, m_axis_tdata);
        end else begin
          want = expected_trees.pop_front();
          if (want !== got) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch exp p=%h c=%h s=%h n=%h o=%b ",
                       $realtime, want.profit_total, want.cost_total, want.tree_score,
                       want.edges_taken, want.overflow_flag,
                       "got p=%h c=%h s=%h n=%h o=%b", got.profit_total,
                       got.cost_total, got.tree_score, got.edges_taken,
                       got.overflow_flag);
          end
        end
      end
    end
    pending = expected_trees.size();
  end

endmodule

`default_nettype wire

[tb/sv/tb_kruskal_max_spanning_tree.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kruskal_max_spanning_tree
// Drives edge graphs and register settings into the spanning tree block; a
// checker beside it predicts and compares every result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_kruskal_max_spanning_tree;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_WORDS = 300;
  localparam int MAX_EDGES = 1024;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [1:0]    cfg_index = kmst_pkg::REG_COST_SCALE;
  logic [15:0]   cfg_data = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [47:0]   s_axis_tdata = '0;
  logic          s_axis_tlast = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [103:0]  m_axis_tdata;
  int            errors;
  int            pending;
  int            cycles = 0;
  bit            calm = 0;
  bit            hold_req = 0;
  int            eff_vc = 256;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  kruskal_max_spanning_tree uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  kmst_scoreboard chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .errors(errors), .pending(pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_kruskal_max_spanning_tree: errors");
      $finish;
    end
  end

  // result side backpressure: random bursts, one long hold on request
  always begin
    @(posedge clk);
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      m_axis_tready <= 1'b0;
      repeat (600) @(posedge clk);
      hold_req = 0;
      m_axis_tready <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // one edge word, with an occasional idle burst ahead of it
  task automatic send_edge(input logic [7:0] f, input logic [7:0] t,
                           input logic [15:0] p, input logic [15:0] c, input bit last);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c, p, t, f};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // stop sending and wait for every pending tree
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] cs, input logic [15:0] gs,
                            input logic [8:0] vc);
    cfg_we    <= 1'b1;
    cfg_index <= kmst_pkg::REG_COST_SCALE;
    cfg_data  <= cs;
    @(posedge clk);
    cfg_index <= kmst_pkg::REG_GAIN_SCALE;
    cfg_data  <= gs;
    @(posedge clk);
    cfg_index <= kmst_pkg::REG_VERTEX_COUNT;
    cfg_data  <= {7'd0, vc};
    @(posedge clk);
    cfg_we <= 1'b0;
    eff_vc = (vc == 9'd0) ? 1 : (vc > 9'd256) ? 256 : int'(vc);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 7));
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [8:0] pick_vcount();
    case ($urandom_range(0, 7))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd256;
      3: return 9'($urandom_range(257, 511));
      4: return 9'd511;
      default: return 9'($urandom_range(2, 12));
    endcase
  endfunction

  // random graph, mostly in-range endpoints with some loops and strays
  task automatic send_graph(input int n);
    logic [7:0] f, t;
    for (int i = 0; i < n; i++) begin
      f = 8'($urandom_range(0, eff_vc - 1));
      t = 8'($urandom_range(0, eff_vc - 1));
      case ($urandom_range(0, 19))
        0: t = f;
        1: f = 8'($urandom);
        2: t = 8'($urandom);
        default: ;
      endcase
      send_edge(f, t, pick_value(), pick_value(), i == n - 1);
    end
  endtask

  initial begin
    int sent;
    int n;
    int graphs;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, extremes, ties, loop, stray endpoint
    send_edge(8'd0, 8'd255, 16'hFFFF, 16'hFFFF, 1);
    send_edge(8'd3, 8'd3, 16'd100, 16'd1, 0);
    send_edge(8'd1, 8'd2, 16'd7, 16'd0, 0);
    send_edge(8'd2, 8'd1, 16'd7, 16'd5, 0);
    send_edge(8'd1, 8'd2, 16'd7, 16'd9, 1);
    drain();
    set_config(16'h8000, 16'h7FFF, 9'd0);
    send_edge(8'd0, 8'd1, 16'hFFFF, 16'h0000, 1);
    drain();
    set_config(16'h7FFF, 16'h8000, 9'd511);
    send_edge(8'd255, 8'd0, 16'h0000, 16'hFFFF, 0);
    send_edge(8'd10, 8'd20, 16'd1, 16'd1, 0);
    send_edge(8'd20, 8'd10, 16'hFFFF, 16'hFFFF, 1);
    drain();
    set_config(16'h0001, 16'h0001, 9'd4);
    send_edge(8'd0, 8'd1, 16'd5, 16'd1, 0);
    send_edge(8'd1, 8'd2, 16'd5, 16'd1, 0);
    send_edge(8'd2, 8'd3, 16'd9, 16'd2, 0);
    send_edge(8'd3, 8'd4, 16'd90, 16'd0, 0);
    send_edge(8'd0, 8'd3, 16'd1, 16'd0, 0);
    send_edge(8'd1, 8'd3, 16'd50, 16'd3, 1);
    drain();
    set_config(16'h0000, 16'h0001, 9'd1);
    send_edge(8'd0, 8'd0, 16'd3, 16'd3, 1);
    drain();

    // store overflow: the final word is dropped but still closes the graph
    set_config(16'h0000, 16'h0001, 9'd2);
    for (int i = 0; i <= MAX_EDGES; i++)
      send_edge(8'd0, 8'd1, 16'($urandom), 16'($urandom), i == MAX_EDGES);
    send_edge(8'd1, 8'd0, 16'd4, 16'd4, 1);
    drain();

    // random phases
    sent = 0;
    graphs = 0;
    while (sent < RANDOM_WORDS) begin
      if (graphs % 8 == 0) begin
        drain();
        set_config(pick_scale(), pick_scale(), pick_vcount());
      end
      if (graphs == 20) hold_req = 1;
      if (sent > RANDOM_WORDS * 85 / 100) calm = 1;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      send_graph(n);
      sent += n;
      graphs++;
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("tb_kruskal_max_spanning_tree: clean");
    else
      $display("tb_kruskal_max_spanning_tree: errors");
    $finish;
  end

endmodule

`default_nettype wire
